// ----- rtl/battery_level_monitor_macros.svh -----
// ----------------------------------------------------------------------------
// Battery level monitor assertion macros
// Concurrent check helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef BATTERY_LEVEL_MONITOR_MACROS_SVH
`define BATTERY_LEVEL_MONITOR_MACROS_SVH

`ifndef SYNTHESIS
// condition holds at every clock edge out of reset
`define BLM_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// antecedent implies consequent in the same cycle
`define BLM_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define BLM_ASSERT_ALWAYS(lbl, cond, msg)
`define BLM_ASSERT_IMPLY(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/blm_pkg.sv -----
// ----------------------------------------------------------------------------
// blm_pkg
// Types and fixed constants of the battery level monitor.
// ----------------------------------------------------------------------------
package blm_pkg;

    localparam int SAMPLE_W  = 10;
    localparam int SAMPLE_MAX = 1023;
    localparam int REG_W     = 10;
    localparam int NUM_REGS  = 8;
    localparam int CFG_IDX_W = 3;
    localparam int LEVEL_W   = 3;
    localparam int SOURCE_W  = 3;
    localparam int SEV_W     = 2;
    localparam int DATA_W    = 16;

    // threshold register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LVL1_DOWN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LVL1_UP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LVL2_DOWN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LVL2_UP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LVL3_DOWN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LVL3_UP   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LVL4_DOWN = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LVL4_UP   = 3'd7;

    localparam logic [REG_W-1:0] REG_RESET [NUM_REGS] = '{
        10'd420, 10'd440, 10'd460, 10'd480, 10'd500, 10'd520, 10'd540, 10'd560
    };

    // levels
    localparam logic [LEVEL_W-1:0] LEVEL_0 = 3'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_1 = 3'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_2 = 3'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_3 = 3'd3;
    localparam logic [LEVEL_W-1:0] LEVEL_4 = 3'd4;

    // request kind carried in tuser
    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_SOURCE = 1'b1;

    // source event codes
    localparam logic [SEV_W-1:0] SEV_USB_IN    = 2'd0;
    localparam logic [SEV_W-1:0] SEV_USB_OUT   = 2'd1;
    localparam logic [SEV_W-1:0] SEV_MAINS_IN  = 2'd2;
    localparam logic [SEV_W-1:0] SEV_MAINS_OUT = 2'd3;

    // recorded source
    localparam logic [SOURCE_W-1:0] SRC_NONE      = 3'd0;
    localparam logic [SOURCE_W-1:0] SRC_USB       = 3'd1;
    localparam logic [SOURCE_W-1:0] SRC_USB_OUT   = 3'd2;
    localparam logic [SOURCE_W-1:0] SRC_MAINS     = 3'd3;
    localparam logic [SOURCE_W-1:0] SRC_MAINS_OUT = 3'd4;

    typedef enum logic [1:0] {
        ST_OFF      = 2'd0,
        ST_ON       = 2'd1,
        ST_COMPLETE = 2'd2
    } status_t;

endpackage

// ----- rtl/battery_level_monitor.sv -----
// ----------------------------------------------------------------------------
// battery_level_monitor
// Sample averaging, five-step level with hysteresis, charge status, shutdown.
// ----------------------------------------------------------------------------
// Each request is either a tick (tuser 0) carrying a battery sample and the
// charger flags, or a source event (tuser 1) saying USB or mains came or went.
// Every request gives exactly one result. The block takes one request per
// clock cycle while m_tready keeps the result register draining: a request is
// held in the input register, is evaluated by one pass of compare-and-add
// logic (block mean by constant reciprocal multiply, blend, threshold chain)
// and lands in the result register, which drives m_tvalid. The result
// register drains while the next request is evaluated; a stall on the master
// side backs up through the input register to s_tready. Thresholds are
// written through cfg_we/cfg_index/cfg_data and should only change while no
// request is in flight.
// ----------------------------------------------------------------------------
`include "battery_level_monitor_macros.svh"

module battery_level_monitor #(
    parameter int AVG_SAMPLES    = 8,
    parameter int SHUTDOWN_TICKS = 70,
    parameter int FULL_THRESHOLD = 580
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration write port
    input  logic                           cfg_we,
    input  logic [blm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [blm_pkg::REG_W-1:0]      cfg_data,
    // request stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [9:0] sample, [10] charger_off, [11] charger_busy, [13:12] source_event
    input  logic [blm_pkg::DATA_W-1:0]     s_tdata,
    // [0] opcode
    input  logic [0:0]                     s_tuser,
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] event_valid, [3:1] level, [6:4] source, [8:7] status,
    // [9] full_flag, [10] power_down
    output logic [blm_pkg::DATA_W-1:0]     m_tdata
);

    import blm_pkg::*;

    // accumulator sized for AVG_SAMPLES full-scale samples
    localparam int SUM_W   = $clog2(AVG_SAMPLES * SAMPLE_MAX + 1);
    localparam int CNT_W   = $clog2(AVG_SAMPLES + 1);
    localparam int SD_W    = $clog2(SHUTDOWN_TICKS + 1);
    // exact floor division by reciprocal: q = (sum * RECIP) >> SHIFT
    localparam int SHIFT   = SUM_W + $clog2(AVG_SAMPLES);
    localparam int RECIP_W = SUM_W + 2;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(AVG_SAMPLES) - 64'd1) / 64'(AVG_SAMPLES);
    localparam logic [RECIP_W-1:0] RECIP    = RECIP_FULL[RECIP_W-1:0];
    localparam logic [CNT_W-1:0]   CNT_LIM  = CNT_W'(AVG_SAMPLES);
    localparam logic [SD_W-1:0]    SD_LIM   = SD_W'(SHUTDOWN_TICKS);
    localparam logic [SAMPLE_W-1:0] FULL_LIM = SAMPLE_W'(FULL_THRESHOLD);
    localparam int PAD_W   = DATA_W - (1 + LEVEL_W + SOURCE_W + 2 + 1 + 1);

    // ------------------------------------------------------------------
    // threshold registers
    // ------------------------------------------------------------------
    logic [REG_W-1:0] lvl_reg [NUM_REGS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                lvl_reg[i] <= REG_RESET[i];
            end
        end
        else if (cfg_we)
        begin
            lvl_reg[cfg_index] <= cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // input register and handshake
    // ------------------------------------------------------------------
    logic                in_valid_reg;
    logic                in_op_reg;
    logic [SAMPLE_W-1:0] in_sample_reg;
    logic                in_off_reg;
    logic                in_busy_reg;
    logic [SEV_W-1:0]    in_sev_reg;
    logic                out_valid_reg;
    logic                advance;

    // evaluate when the result register is free or draining this cycle
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_op_reg     <= s_tuser[0];
            in_sample_reg <= s_tdata[SAMPLE_W-1:0];
            in_off_reg    <= s_tdata[10];
            in_busy_reg   <= s_tdata[11];
            in_sev_reg    <= s_tdata[13:12];
        end
    end

    // ------------------------------------------------------------------
    // monitor state
    // ------------------------------------------------------------------
    logic [SUM_W-1:0]    sample_sum_reg,     sample_sum_next;
    logic [CNT_W-1:0]    sample_count_reg,   sample_count_next;
    logic [SAMPLE_W-1:0] old_avg_reg,        old_avg_next;
    logic [SAMPLE_W-1:0] new_avg_reg,        new_avg_next;
    logic                seeded_reg,         seeded_next;
    logic [LEVEL_W-1:0]  level_reg,          level_next;
    status_t             status_reg,         status_next;
    logic                complete_reg,       complete_next;
    logic [SOURCE_W-1:0] source_reg,         source_next;
    logic                dirty_reg,          dirty_next;
    logic [SD_W-1:0]     sd_count_reg,       sd_count_next;
    logic                ev_next;
    logic                pd_next;

    // block mean and blend
    logic [PROD_W-1:0]   prod;
    logic [SAMPLE_W-1:0] mean;
    logic [SAMPLE_W-1:0] old_eff;
    logic [SAMPLE_W:0]   blend_sum;
    logic [SAMPLE_W-1:0] blend;
    logic [LEVEL_W-1:0]  level_step;

    assign prod      = PROD_W'(sample_sum_reg) * PROD_W'(RECIP);
    assign mean      = prod[SHIFT +: SAMPLE_W];
    assign old_eff   = seeded_reg ? old_avg_reg : mean;
    assign blend_sum = {1'b0, old_eff} + {1'b0, mean};
    assign blend     = blend_sum[SAMPLE_W:1];

    // hysteresis rules, first match wins
    always_comb
    begin
        if (level_reg == LEVEL_3 && blend > lvl_reg[REG_LVL4_UP])
            level_step = LEVEL_4;
        else if (level_reg == LEVEL_4 && blend < lvl_reg[REG_LVL4_DOWN])
            level_step = LEVEL_3;
        else if (level_reg == LEVEL_2 && blend > lvl_reg[REG_LVL3_UP])
            level_step = LEVEL_3;
        else if (level_reg == LEVEL_3 && blend < lvl_reg[REG_LVL3_DOWN])
            level_step = LEVEL_2;
        else if (level_reg == LEVEL_1 && blend > lvl_reg[REG_LVL2_UP])
            level_step = LEVEL_2;
        else if (level_reg == LEVEL_2 && blend < lvl_reg[REG_LVL2_DOWN])
            level_step = LEVEL_1;
        else if (level_reg == LEVEL_0 && blend > lvl_reg[REG_LVL1_UP])
            level_step = LEVEL_1;
        else if (level_reg == LEVEL_1 && blend < lvl_reg[REG_LVL1_DOWN])
            level_step = LEVEL_0;
        else
            level_step = level_reg;
    end

    always_comb
    begin
        sample_sum_next   = sample_sum_reg;
        sample_count_next = sample_count_reg;
        old_avg_next      = old_avg_reg;
        new_avg_next      = new_avg_reg;
        seeded_next       = seeded_reg;
        level_next        = level_reg;
        status_next       = status_reg;
        complete_next     = complete_reg;
        source_next       = source_reg;
        dirty_next        = dirty_reg;
        sd_count_next     = sd_count_reg;
        ev_next           = 1'b0;
        pd_next           = 1'b0;

        if (in_op_reg == OP_SOURCE)
        begin
            sample_sum_next   = '0;
            sample_count_next = '0;
            dirty_next        = 1'b1;
            unique case (in_sev_reg)
                SEV_USB_IN:    source_next = SRC_USB;
                SEV_USB_OUT:
                begin
                    source_next   = SRC_USB_OUT;
                    complete_next = 1'b0;
                end
                SEV_MAINS_IN:  source_next = SRC_MAINS;
                SEV_MAINS_OUT:
                begin
                    source_next   = SRC_MAINS_OUT;
                    complete_next = 1'b0;
                end
                default:       source_next = source_reg;
            endcase
        end
        else
        begin
            if (sample_count_reg < CNT_LIM)
            begin
                sample_count_next = sample_count_reg + CNT_W'(1);
                sample_sum_next   = sample_sum_reg + SUM_W'(in_sample_reg);
            end
            else
            begin
                // block close: this tick's sample is dropped
                seeded_next       = 1'b1;
                new_avg_next      = mean;
                old_avg_next      = blend;
                level_next        = level_step;
                sample_count_next = '0;
                sample_sum_next   = '0;
            end

            if (!in_off_reg)
            begin
                if (status_reg != ST_COMPLETE || new_avg_next <= FULL_LIM)
                    status_next = ST_ON;
            end
            else
            begin
                status_next = ST_OFF;
            end

            if (new_avg_next > FULL_LIM && status_next == ST_ON &&
                !in_busy_reg && level_next == LEVEL_4)
            begin
                complete_next = 1'b1;
                status_next   = ST_COMPLETE;
            end

            ev_next    = (level_next != level_reg) || (status_next != status_reg) ||
                         dirty_reg;
            dirty_next = 1'b0;

            if (level_next == LEVEL_0 && status_next == ST_OFF)
            begin
                if (sd_count_reg < SD_LIM)
                    sd_count_next = sd_count_reg + SD_W'(1);
                else if (sd_count_reg == SD_LIM)
                    pd_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_sum_reg   <= '0;
            sample_count_reg <= '0;
            old_avg_reg      <= '0;
            new_avg_reg      <= '0;
            seeded_reg       <= 1'b0;
            level_reg        <= LEVEL_4;
            status_reg       <= ST_OFF;
            complete_reg     <= 1'b0;
            source_reg       <= SRC_NONE;
            dirty_reg        <= 1'b0;
            sd_count_reg     <= '0;
        end
        else if (advance)
        begin
            sample_sum_reg   <= sample_sum_next;
            sample_count_reg <= sample_count_next;
            old_avg_reg      <= old_avg_next;
            new_avg_reg      <= new_avg_next;
            seeded_reg       <= seeded_next;
            level_reg        <= level_next;
            status_reg       <= status_next;
            complete_reg     <= complete_next;
            source_reg       <= source_next;
            dirty_reg        <= dirty_next;
            sd_count_reg     <= sd_count_next;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    logic                out_ev_reg;
    logic [LEVEL_W-1:0]  out_level_reg;
    logic [SOURCE_W-1:0] out_source_reg;
    status_t             out_status_reg;
    logic                out_full_reg;
    logic                out_pd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_ev_reg     <= ev_next;
            out_level_reg  <= level_next;
            out_source_reg <= source_next;
            out_status_reg <= status_next;
            out_full_reg   <= complete_next;
            out_pd_reg     <= pd_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_pd_reg, out_full_reg, out_status_reg,
                       out_source_reg, out_level_reg, out_ev_reg};

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `BLM_ASSERT_ALWAYS(a_level_range, level_reg <= LEVEL_4, "level above four")
    `BLM_ASSERT_ALWAYS(a_count_bound, sample_count_reg <= CNT_LIM, "sample count overrun")
    `BLM_ASSERT_ALWAYS(a_sd_bound, sd_count_reg <= SD_LIM, "shutdown count overrun")
    `BLM_ASSERT_IMPLY(a_pd_cond, out_valid_reg && out_pd_reg,
        (out_level_reg == LEVEL_0) && (out_status_reg == ST_OFF), "power-down out of state")

endmodule
